[sv/csd_pkg.sv]
`default_nettype none
package csd_pkg;

	localparam int DECK_DEPTH_DEF = 64;
	localparam int HAND_CARDS_DEF = 13;
	localparam int DECK_SIZE_RST  = 52;
	localparam int RAND_W         = 16;
	localparam int SIZE_W         = 7;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_SHUFFLE = 2'd1;
	localparam logic [1:0] OP_DEAL    = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [5:0]        slot;
		logic [7:0]        card_value;
		logic [RAND_W-1:0] random_word;
	} req_t;

	typedef struct packed {
		logic [7:0] card;
		logic       status;
		logic       shuffle_done;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

[sv/csd_mod.sv]
`default_nettype none
module csd_mod #(
	parameter int DW = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [csd_pkg::RAND_W-1:0] dividend,
	input  wire logic [DW-1:0]              divisor,
	output logic                            done,
	output logic [DW-1:0]                   rem
);

	localparam int STEP_W = $clog2(csd_pkg::RAND_W);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [DW-1:0]              rem_q;
	logic [DW-1:0]              dvs_q;
	logic [csd_pkg::RAND_W-1:0] dvd_q;
	logic [DW:0]                trial;
	logic [DW:0]                diff;

	// one restoring remainder bit per cycle
	assign trial = {rem_q, dvd_q[csd_pkg::RAND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= diff[DW-1:0];
				end else begin
					rem_q <= trial[DW-1:0];
				end
				dvd_q  <= {dvd_q[csd_pkg::RAND_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(csd_pkg::RAND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

[sv/csd_deck.sv]
`default_nettype none
module csd_deck #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/card_shuffle_deal.sv]
`default_nettype none
// load and unknown opcode: one result, sent from S_EMIT once the output register is free
// shuffle step: the bit-serial remainder unit picks j (S_DIV), then the swap (S_RDI, S_RDJ, S_WRI, S_WRJ)
// deal: each card is read through the single deck read port (S_DRD) and sent from S_DOUT
// one request at a time; a waiting result does not block the next request
// arst_n clears control state; deck contents are undefined until loaded
module card_shuffle_deal #(
	parameter int DECK_DEPTH = csd_pkg::DECK_DEPTH_DEF,
	parameter int HAND_CARDS = csd_pkg::HAND_CARDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire csd_pkg::req_t               req_data,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output csd_pkg::res_t                    res_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [csd_pkg::SIZE_W-1:0]  cfg_data
);

	localparam int AW = $clog2(DECK_DEPTH);
	localparam int SW = $clog2(DECK_DEPTH + 1);
	localparam int KW = $clog2(HAND_CARDS + 1);
	localparam int CW = SW + 8;
	localparam int RST_SIZE = (csd_pkg::DECK_SIZE_RST > DECK_DEPTH) ? DECK_DEPTH
		: csd_pkg::DECK_SIZE_RST;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_RDI, S_RDJ, S_WRI, S_WRJ, S_EMIT, S_DRD, S_DOUT
	} state_t;

	state_t        state_q;
	logic [SW-1:0] size_q;
	logic [AW-1:0] cnt_q;
	logic [SW-1:0] pos_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] j_q;
	logic [7:0]    ti_q;
	logic          st_q;
	logic          res_valid_q;
	csd_pkg::res_t res_q;

	logic          accept;
	logic          out_free;
	logic          emit;
	logic [SW-1:0] live_cfg;
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_rem;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [CW-1:0] deal_end;
	logic [CW-1:0] deal_addr;
	logic          hand_last;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign emit      = out_free && ((state_q == S_EMIT) || (state_q == S_DOUT));
	assign div_start = accept && (req_data.opcode == csd_pkg::OP_SHUFFLE) && (cnt_q != '0);
	assign deal_end  = CW'(pos_q) + CW'(HAND_CARDS);
	assign deal_addr = CW'(pos_q) + CW'(k_q);
	assign hand_last = (k_q == KW'(HAND_CARDS - 1));

	always_comb begin
		if (cfg_data == '0) begin
			live_cfg = SW'(1);
		end else if (int'(cfg_data) > DECK_DEPTH) begin
			live_cfg = SW'(DECK_DEPTH);
		end else begin
			live_cfg = SW'(cfg_data);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = AW'(req_data.slot);
		wdata = req_data.card_value;
		re    = 1'b0;
		raddr = cnt_q;
		case (state_q)
			S_IDLE: begin
				we = accept && (req_data.opcode == csd_pkg::OP_LOAD)
					&& (int'(req_data.slot) < DECK_DEPTH);
			end
			S_RDI: begin
				re = 1'b1;
			end
			S_RDJ: begin
				re    = 1'b1;
				raddr = j_q;
			end
			S_WRI: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = rdata;
			end
			S_WRJ: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = ti_q;
			end
			S_DRD: begin
				re    = 1'b1;
				raddr = deal_addr[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	csd_mod #(
		.DW(SW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(req_data.random_word),
		.divisor (SW'(cnt_q) + SW'(1)),
		.done    (div_done),
		.rem     (div_rem)
	);

	csd_deck #(
		.DEPTH(DECK_DEPTH),
		.AW   (AW)
	) u_deck (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SW'(RST_SIZE);
			cnt_q       <= AW'(RST_SIZE - 1);
			pos_q       <= '0;
			k_q         <= '0;
			st_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !emit) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						size_q <= live_cfg;
						cnt_q  <= AW'(live_cfg - SW'(1));
						pos_q  <= '0;
					end
					if (accept) begin
						st_q <= 1'b0;
						case (req_data.opcode)
							csd_pkg::OP_LOAD: begin
								cnt_q   <= AW'(size_q - SW'(1));
								pos_q   <= '0;
								state_q <= S_EMIT;
							end
							csd_pkg::OP_SHUFFLE: begin
								state_q <= (cnt_q != '0) ? S_DIV : S_EMIT;
							end
							csd_pkg::OP_DEAL: begin
								k_q <= '0;
								if (deal_end > CW'(size_q)) begin
									st_q    <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_DRD;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						j_q     <= AW'(div_rem);
						state_q <= S_RDI;
					end
				end
				S_RDI: begin
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					ti_q    <= rdata;
					state_q <= S_WRI;
				end
				S_WRI: begin
					state_q <= S_WRJ;
				end
				S_WRJ: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.card         <= '0;
						res_q.status       <= st_q;
						res_q.shuffle_done <= (cnt_q == '0);
						res_q.last         <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.card         <= rdata;
						res_q.status       <= 1'b0;
						res_q.shuffle_done <= (cnt_q == '0);
						res_q.last         <= hand_last;
						k_q                <= k_q + 1'b1;
						if (hand_last) begin
							pos_q   <= deal_end[SW-1:0];
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DEPTH         = csd_pkg::DECK_DEPTH_DEF;
	localparam int HAND          = csd_pkg::HAND_CARDS_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	csd_pkg::req_t              req_data  = '0;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	csd_pkg::res_t              res_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [csd_pkg::SIZE_W-1:0] cfg_data  = '0;

	card_shuffle_deal DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	logic [7:0]                 deck_image [DEPTH];
	int                         shuffle_left;
	int                         deal_at;
	logic [csd_pkg::SIZE_W-1:0] size_reg = csd_pkg::SIZE_W'(csd_pkg::DECK_SIZE_RST);

	csd_pkg::res_t results_due[$];
	csd_pkg::req_t pending_reqs[$];

	int err_count     = 0;
	int queued_items  = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	function automatic int live_cards(input logic [csd_pkg::SIZE_W-1:0] sz);
		if (sz == 0)
			return 1;
		if (sz > DEPTH)
			return DEPTH;
		return int'(sz);
	endfunction

	function automatic void restart_deck();
		shuffle_left = live_cards(size_reg) - 1;
		deal_at = 0;
	endfunction

	function automatic csd_pkg::res_t deck_result(input logic [7:0] c, input logic st,
			input logic lst);
		csd_pkg::res_t r;
		r.card = c;
		r.status = st;
		r.shuffle_done = (shuffle_left == 0);
		r.last = lst;
		return r;
	endfunction

	function automatic void apply_deck_op(input csd_pkg::req_t rq);
		int j;
		int k;
		logic [7:0] t;
		case (rq.opcode)
			csd_pkg::OP_LOAD: begin
				deck_image[rq.slot] = rq.card_value;
				restart_deck();
				results_due.push_back(deck_result(8'd0, 1'b0, 1'b1));
			end
			csd_pkg::OP_SHUFFLE: begin
				if (shuffle_left > 0) begin
					j = int'(rq.random_word) % (shuffle_left + 1);
					t = deck_image[shuffle_left];
					deck_image[shuffle_left] = deck_image[j];
					deck_image[j] = t;
					shuffle_left--;
				end
				results_due.push_back(deck_result(8'd0, 1'b0, 1'b1));
			end
			csd_pkg::OP_DEAL: begin
				if (deal_at + HAND > live_cards(size_reg)) begin
					results_due.push_back(deck_result(8'd0, 1'b1, 1'b1));
				end else begin
					for (k = 0; k < HAND; k++)
						results_due.push_back(deck_result(deck_image[deal_at + k], 1'b0,
							k == HAND - 1));
					deal_at += HAND;
				end
			end
			default: begin
				results_due.push_back(deck_result(8'd0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			err_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			apply_deck_op(req_data);
		if (!req_valid || !req_stall) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req_data <= pending_reqs.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		csd_pkg::res_t want;
		if (res_valid && !res_stall) begin
			if (results_due.size() == 0) begin
				err_count++;
				$error("unexpected result: card %0d status %0d done %0d last %0d",
					res_data.card, res_data.status, res_data.shuffle_done, res_data.last);
			end else begin
				want = results_due.pop_front();
				check_field("card", want.card, res_data.card);
				check_field("status", want.status, res_data.status);
				check_field("shuffle_done", want.shuffle_done, res_data.shuffle_done);
				check_field("last", want.last, res_data.last);
			end
		end
		res_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic queue_req(input logic [1:0] op, input logic [5:0] sl,
			input logic [7:0] val, input logic [15:0] rnd);
		csd_pkg::req_t r;
		r.opcode = op;
		r.slot = sl;
		r.card_value = val;
		r.random_word = rnd;
		pending_reqs.push_back(r);
		queued_items++;
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_deck_size(input logic [csd_pkg::SIZE_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = v;
		restart_deck();
	endtask

	task automatic set_idle(input idle_mode_e m);
		case (m)
			IDLE_SEND: begin
				send_idle_pct = 72;
				stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				stall_pct = 72;
			end
			IDLE_BOTH: begin
				send_idle_pct = 13;
				stall_pct = 13;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// shuffle run, an occasional load, then deals that may run past the end of the deck
	task automatic add_hand_sequence(input int cards);
		int n_shuf;
		int n_deal;
		int i;
		n_shuf = $urandom_range(cards + 2, 0);
		n_deal = $urandom_range(cards / HAND + 2, 1);
		for (i = 0; i < n_shuf; i++)
			queue_req(csd_pkg::OP_SHUFFLE, 6'($urandom), 8'($urandom), 16'($urandom));
		if ($urandom_range(99) < 15)
			queue_req(csd_pkg::OP_LOAD, 6'($urandom), 8'($urandom), 16'($urandom));
		for (i = 0; i < n_deal; i++)
			queue_req(csd_pkg::OP_DEAL, 6'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic random_phase(input logic [csd_pkg::SIZE_W-1:0] sz, input idle_mode_e m,
			input int n, input bit squeeze);
		int start;
		int r;
		set_deck_size(sz);
		set_idle(m);
		if (squeeze)
			hold_reqs++;
		start = queued_items;
		while (queued_items - start < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				add_hand_sequence(live_cards(sz));
			end else if (r < 88) begin
				queue_req(2'($urandom), 6'($urandom), 8'($urandom), 16'($urandom));
			end else begin
				queue_req(csd_pkg::OP_SHUFFLE, 6'($urandom), 8'($urandom), 16'($urandom));
				queue_req(csd_pkg::OP_LOAD, 6'($urandom), 8'($urandom), 16'($urandom));
				queue_req(csd_pkg::OP_DEAL, 6'($urandom), 8'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int k;
		restart_deck();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write every slot so no read ever hits an unwritten entry
		for (k = 0; k < DEPTH; k++)
			queue_req(csd_pkg::OP_LOAD, 6'(k), (k == 0) ? 8'h00 :
				(k == DEPTH - 1) ? 8'hFF : 8'($urandom), 16'($urandom));

		queue_req(csd_pkg::OP_DEAL, 6'h00, 8'h00, 16'h0000);
		queue_req(csd_pkg::OP_SHUFFLE, 6'h00, 8'h00, 16'h0000);
		queue_req(csd_pkg::OP_SHUFFLE, 6'h3F, 8'hFF, 16'hFFFF);
		queue_req(OP_UNUSED, 6'h3F, 8'hFF, 16'hFFFF);
		repeat (4) queue_req(csd_pkg::OP_DEAL, 6'h15, 8'h5A, 16'h1234);

		set_deck_size(7'd1);
		queue_req(csd_pkg::OP_SHUFFLE, 6'h00, 8'h00, 16'hFFFF);
		queue_req(csd_pkg::OP_DEAL, 6'h00, 8'h00, 16'h0000);
		queue_req(OP_UNUSED, 6'h00, 8'h00, 16'h0000);

		set_deck_size(7'd0);
		queue_req(csd_pkg::OP_SHUFFLE, 6'h00, 8'h00, 16'h8001);
		queue_req(csd_pkg::OP_DEAL, 6'h00, 8'h00, 16'h0000);

		set_deck_size(7'd127);
		queue_req(csd_pkg::OP_SHUFFLE, 6'h00, 8'h00, 16'hFFFF);
		repeat (5) queue_req(csd_pkg::OP_DEAL, 6'h2A, 8'hA5, 16'h0000);

		set_deck_size(7'd13);
		queue_req(csd_pkg::OP_DEAL, 6'h00, 8'h00, 16'h0000);
		queue_req(csd_pkg::OP_DEAL, 6'h00, 8'h00, 16'h0000);

		random_phase(7'd64, IDLE_NONE, 20, 1'b0);
		random_phase(7'd26, IDLE_SEND, 20, 1'b0);
		random_phase(7'd127, IDLE_RECV, 20, 1'b0);
		random_phase(7'd0, IDLE_BOTH, 20, 1'b0);
		random_phase(7'd13, IDLE_SEND, 20, 1'b0);
		random_phase(7'd64, IDLE_NONE, 20, 1'b1);
		random_phase(7'd14, IDLE_RECV, 20, 1'b0);
		random_phase(7'd1, IDLE_NONE, 20, 1'b0);
		random_phase(7'($urandom_range(64, 1)), IDLE_BOTH, 20, 1'b0);
		random_phase(7'd52, IDLE_SEND, 20, 1'b0);

		wait_quiet();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
